// File: design/crg_pkg.sv
// ---------------------------------------------------------------------------
// crg_pkg: circle raster generator shared types and constants
// Command codes, the pixel group sequence and the group load control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package crg_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   localparam int GROUP_IDX_BITS = 3;
   localparam logic [GROUP_IDX_BITS-1:0] GROUP_FIRST = 3'd0;
   localparam logic [GROUP_IDX_BITS-1:0] GROUP_LAST  = 3'd7;

   typedef struct packed {
      logic load;
      logic done;
   } grp_ctrl_type;

endpackage

`default_nettype wire

// File: design/crg_req_if.sv
// ---------------------------------------------------------------------------
// crg_req_if: command channel
// Valid/ready channel that carries start and step commands.
// ---------------------------------------------------------------------------
`default_nettype none

interface crg_req_if #(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;

   modport source (output valid, cmd, center_x, center_y, radius, input ready);
   modport sink   (input valid, cmd, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// File: design/crg_rsp_if.sv
// ---------------------------------------------------------------------------
// crg_rsp_if: pixel channel
// Valid/ready channel that carries one plotted pixel per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface crg_rsp_if #(
   parameter int COORD_BITS = 11
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS+1:0] pixel_x;
   logic signed [COORD_BITS+1:0] pixel_y;
   logic                         last_of_group;
   logic                         circle_done;

   modport source (output valid, pixel_x, pixel_y, last_of_group, circle_done,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_of_group, circle_done,
                   output ready);
endinterface

`default_nettype wire

// File: design/crg_emitter.sv
// ---------------------------------------------------------------------------
// crg_emitter: eight-way pixel emitter
// Holds one point group and sends its eight mirrored pixels, one beat per
// cycle while the pixel channel is ready, through a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module crg_emitter #(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire crg_pkg::grp_ctrl_type   grp_ctrl,
   input  wire [COORD_BITS-1:0]         grp_center_x,
   input  wire [COORD_BITS-1:0]         grp_center_y,
   input  wire [RADIUS_BITS:0]          grp_offset_x,
   input  wire [RADIUS_BITS+1:0]        grp_offset_y,
   output logic                         grp_free,
   crg_rsp_if.source                    rsp_chan
);
   import crg_pkg::*;

   localparam int OFFX_W = RADIUS_BITS + 1;
   localparam int OFFY_W = RADIUS_BITS + 2;
   localparam int PIX_W  = COORD_BITS + 2;
   localparam int SUM_W  = ((COORD_BITS > OFFY_W) ? COORD_BITS : OFFY_W) + 2;

   logic                      grp_valid_ff;
   logic [GROUP_IDX_BITS-1:0] idx_ff;
   logic [COORD_BITS-1:0]     cx_ff;
   logic [COORD_BITS-1:0]     cy_ff;
   logic [OFFX_W-1:0]         x_ff;
   logic [OFFY_W-1:0]         y_ff;
   logic                      done_ff;

   logic                      rsp_valid_ff;
   logic [PIX_W-1:0]          pixel_x_ff;
   logic [PIX_W-1:0]          pixel_y_ff;
   logic                      last_ff;
   logic                      circle_done_ff;

   logic                      out_free;
   logic                      fire;
   logic                      at_last;
   logic [SUM_W-1:0]          x_ext;
   logic [SUM_W-1:0]          y_ext;
   logic [SUM_W-1:0]          a_sel;
   logic [SUM_W-1:0]          b_sel;
   logic [SUM_W-1:0]          px_sum;
   logic [SUM_W-1:0]          py_sum;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = grp_valid_ff && out_free;
   assign at_last  = idx_ff == GROUP_LAST;
   assign grp_free = !grp_valid_ff || (fire && at_last);

   // mirror the offsets into the eight octants
   always_comb begin
      x_ext  = SUM_W'(x_ff);
      y_ext  = {{(SUM_W-OFFY_W){y_ff[OFFY_W-1]}}, y_ff};
      a_sel  = idx_ff[2] ? y_ext : x_ext;
      b_sel  = idx_ff[2] ? x_ext : y_ext;
      px_sum = SUM_W'(cx_ff) + (idx_ff[0] ? (SUM_W'(0) - a_sel) : a_sel);
      py_sum = SUM_W'(cy_ff) + (idx_ff[1] ? (SUM_W'(0) - b_sel) : b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= GROUP_FIRST;
      end else if (grp_ctrl.load) begin
         grp_valid_ff <= 1'b1;
         idx_ff       <= GROUP_FIRST;
      end else if (fire) begin
         idx_ff <= idx_ff + GROUP_IDX_BITS'(1);
         if (at_last) begin
            grp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_ctrl.load) begin
         cx_ff   <= grp_center_x;
         cy_ff   <= grp_center_y;
         x_ff    <= grp_offset_x;
         y_ff    <= grp_offset_y;
         done_ff <= grp_ctrl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pixel_x_ff     <= px_sum[PIX_W-1:0];
         pixel_y_ff     <= py_sum[PIX_W-1:0];
         last_ff        <= at_last;
         circle_done_ff <= done_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_x       = pixel_x_ff;
   assign rsp_chan.pixel_y       = pixel_y_ff;
   assign rsp_chan.last_of_group = last_ff;
   assign rsp_chan.circle_done   = circle_done_ff;

endmodule

`default_nettype wire

// File: design/circle_raster_generator.sv
// ---------------------------------------------------------------------------
// circle_raster_generator: midpoint circle rasterizer
// Walks one octant of a circle and emits the eight mirrored pixels per point.
// ---------------------------------------------------------------------------
// A start command latches center and radius and yields the eight pixels of
// the point (0, r); each step command advances the octant walk by one point
// and yields its eight pixels, the last group flagged with circle_done. A
// step with no circle in progress is taken and yields nothing. Pixels leave
// one beat per cycle while the pixel channel is ready, drained through the
// single output register; the first pixel of a command passes the group
// register and then the output register. The next command is taken in the
// cycle the previous group's eighth pixel enters the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_raster_generator #(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
) (
   input  wire        clock,
   input  wire        reset,
   crg_req_if.sink    req_chan,
   crg_rsp_if.source  rsp_chan
);
   import crg_pkg::*;

   localparam int OFFX_W = RADIUS_BITS + 1;
   localparam int OFFY_W = RADIUS_BITS + 2;
   localparam int DEC_W  = RADIUS_BITS + 6;
   localparam int CMP_W  = RADIUS_BITS + 3;

   logic [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic [OFFX_W-1:0]     offset_x_ff, offset_x_in;
   logic [OFFY_W-1:0]     offset_y_ff, offset_y_in;
   logic [DEC_W-1:0]      decision_ff, decision_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  is_start;
   logic                  grp_free;
   grp_ctrl_type          grp_ctrl;

   logic [OFFX_W-1:0]     x_step;
   logic [OFFY_W-1:0]     y_step;
   logic                  dec_pos;
   logic [DEC_W-1:0]      x_dext;
   logic [DEC_W-1:0]      y_dext;
   logic [DEC_W-1:0]      dec_step;
   logic                  step_done;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_start = req_chan.cmd == CMD_START;
   assign req_chan.ready = grp_free;

   // one octant step
   always_comb begin
      x_step    = offset_x_ff + OFFX_W'(1);
      dec_pos   = !decision_ff[DEC_W-1] && (|decision_ff);
      y_step    = dec_pos ? (offset_y_ff - OFFY_W'(1)) : offset_y_ff;
      x_dext    = DEC_W'(x_step);
      y_dext    = {{(DEC_W-OFFY_W){y_step[OFFY_W-1]}}, y_step};
      dec_step  = dec_pos ? (decision_ff + ((x_dext - y_dext) << 2) + DEC_W'(10))
                          : (decision_ff + (x_dext << 2) + DEC_W'(6));
      step_done = $signed({y_step[OFFY_W-1], y_step}) < $signed(CMP_W'(x_step));
   end

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      grp_ctrl    = '0;
      if (accept && is_start) begin
         center_x_in   = req_chan.center_x;
         center_y_in   = req_chan.center_y;
         offset_x_in   = '0;
         offset_y_in   = OFFY_W'(req_chan.radius);
         decision_in   = DEC_W'(3) - (DEC_W'(req_chan.radius) << 1);
         active_in     = 1'b1;
         grp_ctrl.load = 1'b1;
      end else if (accept && active_ff) begin
         offset_x_in   = x_step;
         offset_y_in   = y_step;
         decision_in   = dec_step;
         active_in     = !step_done;
         grp_ctrl.load = 1'b1;
         grp_ctrl.done = step_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
      end
   end

   crg_emitter #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_emitter (
      .clock        (clock),
      .reset        (reset),
      .grp_ctrl     (grp_ctrl),
      .grp_center_x (center_x_in),
      .grp_center_y (center_y_in),
      .grp_offset_x (offset_x_in),
      .grp_offset_y (offset_y_in),
      .grp_free     (grp_free),
      .rsp_chan     (rsp_chan)
   );

   a_start_loads_group: assert property (@(posedge clock) disable iff (reset)
      accept && is_start |=> !grp_free)
      else $error("start beat did not occupy the pixel group");

   a_active_ends_on_step: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) && !$past(reset) |-> $past(accept) && $past(req_chan.cmd == CMD_STEP))
      else $error("circle ended without a step beat");

   a_idle_step_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !is_start && !active_ff |=> $stable(offset_x_ff) && $stable(decision_ff))
      else $error("step with no circle changed the walk state");

endmodule

`default_nettype wire

// File: tb/sv/tb_circle_raster_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_circle_raster_generator: midpoint circle rasterizer testbench
// Drives start and step commands over the command channel and checks every
// pixel beat against an in-bench model of the octant walk. A directed part
// covers idle steps, zero and full radii, extreme centers and restarts. A
// random part walks many circles, with random idling on both channels. A separate
// test applies one long pixel-side hold that backs up the command channel.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_circle_raster_generator;
   import crg_pkg::*;

   localparam int COORD_BITS  = 11;
   localparam int RADIUS_BITS = 10;
   localparam int PIX_BITS    = COORD_BITS + 2;
   localparam int OFFX_BITS   = RADIUS_BITS + 1;
   localparam int OFFY_BITS   = RADIUS_BITS + 2;
   localparam int DEC_BITS    = RADIUS_BITS + 6;
   localparam int CMD_TARGET  = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 16;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic signed [PIX_BITS-1:0] pixel_x;
      logic signed [PIX_BITS-1:0] pixel_y;
      logic                       last_of_group;
      logic                       circle_done;
   } pixel_type;

   logic clock;
   logic reset;

   crg_req_if #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) req_if ();
   crg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   circle_raster_generator #(
      .COORD_BITS (COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   pixel_type pixel_q[$];
   int        error_count = 0;
   int        cmds_sent   = 0;
   bit        quiet       = 1'b0;
   int        hold_len    = 0;
   logic      hold_rsp    = 1'b0;

   logic        [COORD_BITS-1:0] mdl_cx;
   logic        [COORD_BITS-1:0] mdl_cy;
   logic        [OFFX_BITS-1:0]  mdl_ox;
   logic signed [OFFY_BITS-1:0]  mdl_oy;
   logic signed [DEC_BITS-1:0]   mdl_dec;
   bit                           mdl_active;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_circle_raster_generator: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // model of the octant walk
   // ------------------------------------------------------------------
   function automatic void push_pixel(int px, int py, bit last, bit done);
      pixel_type p;
      p.pixel_x       = px[PIX_BITS-1:0];
      p.pixel_y       = py[PIX_BITS-1:0];
      p.last_of_group = last;
      p.circle_done   = done;
      pixel_q.push_back(p);
   endfunction

   function automatic void plot_octants(bit done);
      int cx;
      int cy;
      int x;
      int y;
      cx = int'(mdl_cx);
      cy = int'(mdl_cy);
      x  = int'(mdl_ox);
      y  = int'(mdl_oy);
      push_pixel(cx + x, cy + y, 1'b0, done);
      push_pixel(cx - x, cy + y, 1'b0, done);
      push_pixel(cx + x, cy - y, 1'b0, done);
      push_pixel(cx - x, cy - y, 1'b0, done);
      push_pixel(cx + y, cy + x, 1'b0, done);
      push_pixel(cx - y, cy + x, 1'b0, done);
      push_pixel(cx + y, cy - x, 1'b0, done);
      push_pixel(cx - y, cy - x, 1'b1, done);
   endfunction

   function automatic void predict_cmd(cmd_type c, logic [COORD_BITS-1:0] cx,
                                       logic [COORD_BITS-1:0] cy,
                                       logic [RADIUS_BITS-1:0] r);
      int  rad;
      int  x;
      int  y;
      int  dec;
      bit  done;
      if (c == CMD_START) begin
         rad        = int'(r);
         dec        = 3 - 2 * rad;
         mdl_cx     = cx;
         mdl_cy     = cy;
         mdl_ox     = '0;
         mdl_oy     = rad[OFFY_BITS-1:0];
         mdl_dec    = dec[DEC_BITS-1:0];
         mdl_active = 1'b1;
         plot_octants(1'b0);
      end else if (mdl_active) begin
         mdl_ox = mdl_ox + 1'b1;
         x      = int'(mdl_ox);
         dec    = int'(mdl_dec);
         if (mdl_dec > 0) begin
            mdl_oy = mdl_oy - 1'b1;
            y      = int'(mdl_oy);
            dec    = dec + 4 * (x - y) + 10;
         end else begin
            y   = int'(mdl_oy);
            dec = dec + 4 * x + 6;
         end
         mdl_dec = dec[DEC_BITS-1:0];
         done    = (y < x);
         if (done) mdl_active = 1'b0;
         plot_octants(done);
      end
   endfunction

   // ------------------------------------------------------------------
   // command side
   // ------------------------------------------------------------------
   task automatic send_cmd(cmd_type c, logic [COORD_BITS-1:0] cx,
                           logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
      int gap;
      req_if.valid    <= 1'b1;
      req_if.cmd      <= c;
      req_if.center_x <= cx;
      req_if.center_y <= cy;
      req_if.radius   <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_cmd(c, cx, cy, r);
      cmds_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_step();
      send_cmd(CMD_STEP, COORD_BITS'($urandom_range(0, 2047)),
               COORD_BITS'($urandom_range(0, 2047)),
               RADIUS_BITS'($urandom_range(0, 1023)));
   endtask

   task automatic finish_circle();
      while (mdl_active) send_step();
   endtask

   // ------------------------------------------------------------------
   // pixel side
   // ------------------------------------------------------------------
   initial begin
      int stall_left;
      int gap;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               stall_left = gap - 1;
               rsp_if.ready <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the pixel channel, counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_rsp <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_rsp <= 1'b0;
            hold_len = 0;
         end
      end
   end

   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b", $realtime,
                     rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.last_of_group,
                     rsp_if.circle_done);
            error_count++;
         end else begin
            exp_px = pixel_q.pop_front();
            if (rsp_if.pixel_x !== exp_px.pixel_x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $realtime,
                        exp_px.pixel_x, rsp_if.pixel_x);
               error_count++;
            end
            if (rsp_if.pixel_y !== exp_px.pixel_y) begin
               $display("%0t: pixel_y expected %0d actual %0d", $realtime,
                        exp_px.pixel_y, rsp_if.pixel_y);
               error_count++;
            end
            if (rsp_if.last_of_group !== exp_px.last_of_group) begin
               $display("%0t: last_of_group expected %0b actual %0b", $realtime,
                        exp_px.last_of_group, rsp_if.last_of_group);
               error_count++;
            end
            if (rsp_if.circle_done !== exp_px.circle_done) begin
               $display("%0t: circle_done expected %0b actual %0b", $realtime,
                        exp_px.circle_done, rsp_if.circle_done);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_idle_step();
      send_cmd(CMD_STEP, '1, '1, '1);
      send_cmd(CMD_STEP, '0, '0, '0);
   endtask

   task automatic test_zero_radius();
      send_cmd(CMD_START, '0, '0, '0);
      send_step();
      send_step();
   endtask

   task automatic test_small_circles();
      send_cmd(CMD_START, 11'd5, 11'd7, 10'd1);
      finish_circle();
      send_cmd(CMD_START, 11'd100, 11'd200, 10'd3);
      finish_circle();
   endtask

   task automatic test_extremes();
      send_cmd(CMD_START, 11'd2047, 11'd2047, 10'd1023);
      send_step();
      send_step();
      send_cmd(CMD_START, 11'd0, 11'd0, 10'd1023);
      send_step();
      send_cmd(CMD_START, 11'd2047, 11'd0, 10'd0);
      send_step();
   endtask

   task automatic test_restart();
      send_cmd(CMD_START, 11'd1024, 11'd1024, 10'd10);
      send_step();
      send_step();
      send_cmd(CMD_START, 11'd3, 11'd3, 10'd2);
      finish_circle();
   endtask

   task automatic test_backpressure();
      quiet    = 1'b1;
      hold_len = HOLD_CYCLES;
      send_cmd(CMD_START, COORD_BITS'($urandom_range(0, 2047)),
               COORD_BITS'($urandom_range(0, 2047)), 10'd20);
      repeat (10) send_step();
      quiet = 1'b0;
   endtask

   task automatic test_random_circles();
      int kind;
      int cap;
      int n;
      logic [COORD_BITS-1:0]  cx;
      logic [COORD_BITS-1:0]  cy;
      logic [RADIUS_BITS-1:0] r;
      while (cmds_sent < CMD_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         kind  = $urandom_range(0, 9);
         if (kind < 8) begin
            case ($urandom_range(0, 9))
               0, 1:    r = RADIUS_BITS'($urandom_range(0, 1023));
               2:       r = RADIUS_BITS'($urandom_range(1000, 1023));
               default: r = RADIUS_BITS'($urandom_range(0, 40));
            endcase
            cx = COORD_BITS'($urandom_range(0, 2047));
            cy = COORD_BITS'($urandom_range(0, 2047));
            if ($urandom_range(0, 4) == 0) cx = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 4) == 0) cy = $urandom_range(0, 1) ? '1 : '0;
            send_cmd(CMD_START, cx, cy, r);
            cap = (r <= 60) ? 1000 : $urandom_range(3, 30);
            n   = 0;
            while (mdl_active && n < cap) begin
               send_step();
               n++;
            end
            if (!mdl_active && $urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) send_step();
         end else begin
            repeat ($urandom_range(1, 4))
               send_cmd($urandom_range(0, 1) ? CMD_STEP : CMD_START,
                        COORD_BITS'($urandom_range(0, 2047)),
                        COORD_BITS'($urandom_range(0, 2047)),
                        RADIUS_BITS'($urandom_range(0, 40)));
         end
      end
      quiet = 1'b0;
   endtask

   task automatic wait_drain();
      int n;
      n = 0;
      req_if.valid <= 1'b0;
      while (pixel_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pixel_q.size() != 0) begin
         $display("%0t: %0d pixels never arrived", $realtime, pixel_q.size());
         error_count++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      mdl_cx          = '0;
      mdl_cy          = '0;
      mdl_ox          = '0;
      mdl_oy          = '0;
      mdl_dec         = '0;
      mdl_active      = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cmd      = CMD_START;
      req_if.center_x = '0;
      req_if.center_y = '0;
      req_if.radius   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_step();
      test_zero_radius();
      test_small_circles();
      test_extremes();
      test_restart();
      test_backpressure();
      test_random_circles();
      wait_drain();

      if (error_count == 0) begin
         $display("tb_circle_raster_generator: PASS");
      end else begin
         $display("tb_circle_raster_generator: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: circle_raster_generator.f
design/crg_pkg.sv
design/crg_req_if.sv
design/crg_rsp_if.sv
design/crg_emitter.sv
design/circle_raster_generator.sv
tb/sv/tb_circle_raster_generator.sv
